// ----- sv/ttd_pkg.sv -----
package ttd_pkg;

    // Table depth default
    localparam int MAX_KNOTS_DEF = 256;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int DIST_W   = 32;
    localparam int SPEED_W  = 24;
    localparam int ACCEL_W  = 24;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int EPS_W    = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int KNOT_COUNT_RST = 2;
    localparam int ACCEL_EPS_RST  = 66;

    // Shared unit widths
    localparam int DIV_NUM_W   = 48;
    localparam int DIV_DEN_W   = 32;
    localparam int DIV_CNT_W   = 6;
    localparam int MUL_A_W     = 24;
    localparam int MUL_B_W     = 34;
    localparam int PROD_W      = 58;
    localparam int ARG_W       = 60;
    localparam int SQ_W        = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KNOT_COUNT = 1'b0,
        REG_ACCEL_EPS  = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        REQ_STORE = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED     = 2'd0,
        ST_OK         = 2'd1,
        ST_ZERO_SPEED = 2'd2,
        ST_CLAMPED    = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_DIV_A,
        S_ACLAMP,
        S_MODE,
        S_MUL_AD,
        S_MUL_VV,
        S_ARG,
        S_SQRT,
        S_ROOT,
        S_DIV_T,
        S_DT,
        S_FIN,
        S_DONE
    } t_state;

endpackage

// ----- sv/ttd_req_if.sv -----
interface ttd_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [ttd_pkg::INDEX_W-1:0]      knot_index;
    logic [ttd_pkg::TIME_W-1:0]       knot_time;
    logic [ttd_pkg::DIST_W-1:0]       knot_dist;
    logic [ttd_pkg::SPEED_W-1:0]      knot_speed;
    logic [ttd_pkg::DIST_W-1:0]       query_dist;

    modport source (
        output valid, req_type, knot_index, knot_time, knot_dist, knot_speed, query_dist,
        input  ready
    );
    modport sink (
        input  valid, req_type, knot_index, knot_time, knot_dist, knot_speed, query_dist,
        output ready
    );
endinterface

// ----- sv/ttd_rsp_if.sv -----
interface ttd_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [ttd_pkg::STATUS_W-1:0]       status;
    logic [ttd_pkg::TIME_W-1:0]         out_time;
    logic [ttd_pkg::SPEED_W-1:0]        out_speed;
    logic signed [ttd_pkg::ACCEL_W-1:0] out_accel;
    logic [ttd_pkg::INDEX_W-1:0]        out_segment;

    modport source (
        output valid, status, out_time, out_speed, out_accel, out_segment,
        input  ready
    );
    modport sink (
        input  valid, status, out_time, out_speed, out_accel, out_segment,
        output ready
    );
endinterface

// ----- sv/trajectory_time_by_distance.sv -----
// Trajectory lookup: time, speed and acceleration at a given arc length.
//
// Channels: i_req carries one request per beat. A store writes one knot (time,
// distance, speed) at knot_index; a query carries query_dist. o_rsp returns
// exactly one beat per request. Configuration (knot_count, accel_epsilon) must
// be written on the write port only while idle; the block does not enforce it.
//
// Sequence: a store beat goes straight to the DONE state. A query scans the
// knot table one entry per cycle, reads the segment knots (states RD0 to RD3),
// runs a serial divide for the segment acceleration unless the two knot times
// are equal, and then either a divide (linear motion with nonzero speed) or a
// root setup (MUL_AD, MUL_VV, ARG), a serial square root and a divide. The
// table scan and the shared serial divider set how long a query takes.
// One request is in flight at a time; i_req.ready is high only while idle.
//
// Reset clears the controller, the output valid flag and the configuration
// (knot_count 2, accel_epsilon 66); the knot table holds no reset value.
// A stalled receiver holds the result in the output register; the next
// request is taken meanwhile and its result waits until the register frees.
module trajectory_time_by_distance #(
    parameter int MAX_KNOTS = ttd_pkg::MAX_KNOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [ttd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ttd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ttd_req_if.sink                          i_req,
    ttd_rsp_if.source                        o_rsp
);

    localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int CW = $clog2(MAX_KNOTS + 1);
    localparam int DIV_STEPS = ttd_pkg::DIV_NUM_W;
    localparam logic [ttd_pkg::SQ_W-1:0] SQ_BIT0 = {2'b01, {(ttd_pkg::SQ_W-2){1'b0}}};

    // Configuration
    logic [ttd_pkg::COUNT_W-1:0] r_knot_count;
    logic [ttd_pkg::EPS_W-1:0]   r_accel_eps;

    // Knot table
    logic [ttd_pkg::TIME_W-1:0]  mem_t [MAX_KNOTS];
    logic [ttd_pkg::DIST_W-1:0]  mem_d [MAX_KNOTS];
    logic [ttd_pkg::SPEED_W-1:0] mem_v [MAX_KNOTS];
    logic [ttd_pkg::TIME_W-1:0]  r_rd_t;
    logic [ttd_pkg::DIST_W-1:0]  r_rd_d;
    logic [ttd_pkg::SPEED_W-1:0] r_rd_v;

    // Sequencer
    ttd_pkg::t_state r_state, n_state;

    // Query context
    logic [ttd_pkg::DIST_W-1:0]  r_q;
    logic [CW-1:0]               r_k;
    logic                        r_pend;
    logic [CW-1:0]               r_seg;
    logic [ttd_pkg::TIME_W-1:0]  r_t0, r_t1;
    logic [ttd_pkg::DIST_W-1:0]  r_d0, r_dlast;
    logic [ttd_pkg::SPEED_W-1:0] r_v0, r_v1;
    logic [ttd_pkg::DIST_W-1:0]  r_ds_mag;
    logic                        r_ds_neg;
    logic signed [ttd_pkg::ACCEL_W-1:0] r_a;
    logic [ttd_pkg::MUL_B_W-1:0] r_dt_mag;
    logic                        r_dt_neg;
    logic                        r_zero;
    ttd_pkg::t_status            r_status;

    // Serial divider
    logic [ttd_pkg::DIV_NUM_W-1:0] r_dnum;
    logic [ttd_pkg::DIV_DEN_W-1:0] r_drem;
    logic [ttd_pkg::DIV_DEN_W-1:0] r_dden;
    logic [ttd_pkg::DIV_CNT_W-1:0] r_dcnt;
    logic                          r_dneg;

    // Shared multiplier
    logic [ttd_pkg::MUL_A_W-1:0] w_mul_a;
    logic [ttd_pkg::MUL_B_W-1:0] w_mul_b;
    logic [ttd_pkg::PROD_W-1:0]  r_prod;
    logic [ttd_pkg::PROD_W-1:0]  r_pad;

    // Serial square root
    logic [ttd_pkg::SQ_W-1:0] r_sx, r_sres, r_sbit;

    // Output register
    logic                               r_out_valid;
    logic [ttd_pkg::STATUS_W-1:0]       r_o_status;
    logic [ttd_pkg::TIME_W-1:0]         r_o_time;
    logic [ttd_pkg::SPEED_W-1:0]        r_o_speed;
    logic signed [ttd_pkg::ACCEL_W-1:0] r_o_accel;
    logic [ttd_pkg::INDEX_W-1:0]        r_o_segment;
    logic [ttd_pkg::TIME_W-1:0]         r_res_time;
    logic [ttd_pkg::SPEED_W-1:0]        r_res_speed;

    // Control outputs
    logic          w_in_ready;
    logic [AW-1:0] w_rd_addr;

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    logic [CW-1:0] w_n;
    logic          w_accept, w_store_wr, w_out_free;
    logic          w_found, w_scan_done;
    logic [CW-1:0] w_first, w_seg_raw, w_seg;
    logic          w_div_last;
    logic [ttd_pkg::DIV_DEN_W:0] w_rem_sh;
    logic          w_dge;
    logic [ttd_pkg::SQ_W-1:0] w_sq_try;
    logic          w_sq_ge;
    logic signed [ttd_pkg::SPEED_W:0]     w_dv;
    logic [ttd_pkg::SPEED_W:0]            w_dv_mag;
    logic signed [ttd_pkg::TIME_W:0]      w_dtk;
    logic [ttd_pkg::TIME_W-1:0]           w_dtk_mag;
    logic signed [ttd_pkg::DIST_W:0]      w_ds;
    logic [ttd_pkg::ACCEL_W-1:0]          w_abs_a;
    logic          w_a_neg, w_linear;
    logic [ttd_pkg::ARG_W-1:0]            w_arg;
    logic [31:0]                          w_diff, w_diff_mag;
    logic [ttd_pkg::MUL_B_W-1:0]          w_dt_clamp;
    logic signed [ttd_pkg::ACCEL_W-1:0]   w_a_clamp;
    logic signed [35:0]                   w_dt_s, w_tm_s;
    logic [41:0]                          w_pr;
    logic signed [43:0]                   w_spd_s;
    logic [ttd_pkg::TIME_W-1:0]           w_tm;
    logic [ttd_pkg::SPEED_W-1:0]          w_spd;

    always_comb begin
        if (r_knot_count < ttd_pkg::COUNT_W'(2)) begin
            w_n = CW'(2);
        end else if (32'(r_knot_count) > MAX_KNOTS) begin
            w_n = CW'(MAX_KNOTS);
        end else begin
            w_n = CW'(r_knot_count);
        end
    end

    assign w_accept   = i_req.valid && w_in_ready;
    assign w_store_wr = w_accept && (i_req.req_type == ttd_pkg::REQ_STORE)
                        && (32'(i_req.knot_index) < MAX_KNOTS);
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Scan: the data register holds the knot at r_k - 1 when r_pend is set
    assign w_found     = r_pend && (r_rd_d >= r_q);
    assign w_scan_done = r_pend && (w_found || (r_k == w_n));
    assign w_first     = w_found ? (r_k - CW'(1)) : w_n;
    assign w_seg_raw   = (w_first == '0) ? '0 : (w_first - CW'(1));
    assign w_seg       = (w_seg_raw > (w_n - CW'(2))) ? (w_n - CW'(2)) : w_seg_raw;

    // Divider step
    assign w_div_last = (r_dcnt == ttd_pkg::DIV_CNT_W'(1));
    assign w_rem_sh   = {r_drem, r_dnum[ttd_pkg::DIV_NUM_W-1]};
    assign w_dge      = w_rem_sh >= {1'b0, r_dden};

    // Square-root step
    assign w_sq_try = r_sres + r_sbit;
    assign w_sq_ge  = r_sx >= w_sq_try;

    // Segment deltas
    assign w_dv      = $signed({1'b0, r_v1}) - $signed({1'b0, r_v0});
    assign w_dv_mag  = w_dv[ttd_pkg::SPEED_W] ? ttd_pkg::SPEED_W'(0) - w_dv : w_dv;
    assign w_dtk     = $signed({1'b0, r_t1}) - $signed({1'b0, r_t0});
    assign w_dtk_mag = w_dtk[ttd_pkg::TIME_W] ? ttd_pkg::TIME_W'(-w_dtk)
                                              : w_dtk[ttd_pkg::TIME_W-1:0];
    assign w_ds      = $signed({1'b0, r_q}) - $signed({1'b0, r_d0});

    assign w_a_neg   = r_a[ttd_pkg::ACCEL_W-1];
    assign w_abs_a   = w_a_neg ? ttd_pkg::ACCEL_W'(-r_a) : r_a;
    assign w_linear  = (w_abs_a < ttd_pkg::ACCEL_W'(r_accel_eps)) || (r_a == '0)
                       || (r_q > r_dlast);

    // Root argument: v0^2 +/- 2*|a*ds|
    assign w_arg = (w_a_neg ^ r_ds_neg)
                   ? {12'b0, r_prod[47:0]} - {1'b0, r_pad, 1'b0}
                   : {12'b0, r_prod[47:0]} + {1'b0, r_pad, 1'b0};

    assign w_diff     = {1'b0, r_sres[30:0]} - {8'b0, r_v0};
    assign w_diff_mag = w_diff[31] ? (32'd0 - w_diff) : w_diff;

    // Acceleration and time-step saturation from the divider quotient
    always_comb begin
        if (!r_dneg) begin
            w_a_clamp = (r_dnum > 48'd8388607) ? 24'sh7FFFFF
                                                : $signed(r_dnum[ttd_pkg::ACCEL_W-1:0]);
        end else begin
            w_a_clamp = (r_dnum > 48'd8388608) ? 24'sh800000
                                                : -$signed(r_dnum[ttd_pkg::ACCEL_W-1:0]);
        end
    end
    assign w_dt_clamp = (r_dnum > 48'h2_0000_0000) ? 34'h2_0000_0000
                                                   : r_dnum[ttd_pkg::MUL_B_W-1:0];

    // Final time and speed
    assign w_dt_s  = r_dt_neg ? -$signed({2'b0, r_dt_mag}) : $signed({2'b0, r_dt_mag});
    assign w_tm_s  = $signed({4'b0, r_t0}) + w_dt_s;
    assign w_pr    = r_prod[ttd_pkg::PROD_W-1:16];
    assign w_spd_s = (w_a_neg ^ r_dt_neg) ? $signed({20'b0, r_v0}) - $signed({2'b0, w_pr})
                                          : $signed({20'b0, r_v0}) + $signed({2'b0, w_pr});

    always_comb begin
        if (w_tm_s[35]) begin
            w_tm = '0;
        end else if (w_tm_s[34:32] != 3'b0) begin
            w_tm = '1;
        end else begin
            w_tm = w_tm_s[31:0];
        end
        if (w_spd_s[43]) begin
            w_spd = '0;
        end else if (w_spd_s[42:24] != '0) begin
            w_spd = '1;
        end else begin
            w_spd = w_spd_s[23:0];
        end
    end

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ttd_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.req_type == ttd_pkg::REQ_QUERY) ? ttd_pkg::S_SCAN
                                                                      : ttd_pkg::S_DONE;
                end
            end
            ttd_pkg::S_SCAN:   if (w_scan_done) n_state = ttd_pkg::S_RD0;
            ttd_pkg::S_RD0:    n_state = ttd_pkg::S_RD1;
            ttd_pkg::S_RD1:    n_state = ttd_pkg::S_RD2;
            ttd_pkg::S_RD2:    n_state = ttd_pkg::S_RD3;
            ttd_pkg::S_RD3:    n_state = (w_dtk == '0) ? ttd_pkg::S_MODE : ttd_pkg::S_DIV_A;
            ttd_pkg::S_DIV_A:  if (w_div_last) n_state = ttd_pkg::S_ACLAMP;
            ttd_pkg::S_ACLAMP: n_state = ttd_pkg::S_MODE;
            ttd_pkg::S_MODE: begin
                if (!w_linear) begin
                    n_state = ttd_pkg::S_MUL_AD;
                end else if (r_v0 == '0) begin
                    n_state = ttd_pkg::S_FIN;
                end else begin
                    n_state = ttd_pkg::S_DIV_T;
                end
            end
            ttd_pkg::S_MUL_AD: n_state = ttd_pkg::S_MUL_VV;
            ttd_pkg::S_MUL_VV: n_state = ttd_pkg::S_ARG;
            ttd_pkg::S_ARG:    n_state = ttd_pkg::S_SQRT;
            ttd_pkg::S_SQRT:   if (r_sbit[0]) n_state = ttd_pkg::S_ROOT;
            ttd_pkg::S_ROOT:   n_state = ttd_pkg::S_DIV_T;
            ttd_pkg::S_DIV_T:  if (w_div_last) n_state = ttd_pkg::S_DT;
            ttd_pkg::S_DT:     n_state = ttd_pkg::S_FIN;
            ttd_pkg::S_FIN:    n_state = ttd_pkg::S_DONE;
            ttd_pkg::S_DONE:   if (w_out_free) n_state = ttd_pkg::S_IDLE;
            default:           n_state = ttd_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Control outputs: handshake, table address, multiplier operands
    // ---------------------------------------------------------------
    always_comb begin
        w_in_ready = 1'b0;
        w_rd_addr  = AW'(r_k);
        w_mul_a    = w_abs_a;
        w_mul_b    = ttd_pkg::MUL_B_W'(r_ds_mag);
        case (r_state)
            ttd_pkg::S_IDLE:   w_in_ready = 1'b1;
            ttd_pkg::S_RD0:    w_rd_addr  = AW'(r_seg);
            ttd_pkg::S_RD1:    w_rd_addr  = AW'(r_seg + CW'(1));
            ttd_pkg::S_RD2:    w_rd_addr  = AW'(w_n - CW'(1));
            ttd_pkg::S_MUL_VV: begin
                w_mul_a = r_v0;
                w_mul_b = ttd_pkg::MUL_B_W'(r_v0);
            end
            ttd_pkg::S_DT:     w_mul_b = w_dt_clamp;
            default: begin
            end
        endcase
    end

    assign i_req.ready = w_in_ready;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= ttd_pkg::COUNT_W'(ttd_pkg::KNOT_COUNT_RST);
            r_accel_eps  <= ttd_pkg::EPS_W'(ttd_pkg::ACCEL_EPS_RST);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ttd_pkg::REG_KNOT_COUNT: r_knot_count <= i_cfg_data[ttd_pkg::COUNT_W-1:0];
                ttd_pkg::REG_ACCEL_EPS:  r_accel_eps  <= i_cfg_data[ttd_pkg::EPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Write and read the knot table
    always_ff @(posedge i_clk) begin
        if (w_store_wr) begin
            mem_t[AW'(i_req.knot_index)] <= i_req.knot_time;
            mem_d[AW'(i_req.knot_index)] <= i_req.knot_dist;
            mem_v[AW'(i_req.knot_index)] <= i_req.knot_speed;
        end
        r_rd_t <= mem_t[w_rd_addr];
        r_rd_d <= mem_d[w_rd_addr];
        r_rd_v <= mem_v[w_rd_addr];
    end

    // Advance the sequencer and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ttd_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Shared multiplier, one registered product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= {{(ttd_pkg::PROD_W-ttd_pkg::MUL_A_W){1'b0}}, w_mul_a}
                * {{(ttd_pkg::PROD_W-ttd_pkg::MUL_B_W){1'b0}}, w_mul_b};
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ttd_pkg::S_IDLE: begin
                r_q    <= i_req.query_dist;
                r_k    <= '0;
                r_pend <= 1'b0;
                r_zero <= 1'b0;
                if (w_accept) begin
                    r_status    <= (i_req.req_type == ttd_pkg::REQ_QUERY) ? ttd_pkg::ST_OK
                                                                           : ttd_pkg::ST_STORED;
                    r_res_time  <= '0;
                    r_res_speed <= '0;
                    r_a         <= '0;
                    r_seg       <= '0;
                end
            end
            ttd_pkg::S_SCAN: begin
                if (r_k < w_n) begin
                    r_k    <= r_k + CW'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                r_seg <= w_seg;
            end
            ttd_pkg::S_RD1: begin
                r_t0 <= r_rd_t;
                r_d0 <= r_rd_d;
                r_v0 <= r_rd_v;
            end
            ttd_pkg::S_RD2: begin
                r_t1 <= r_rd_t;
                r_v1 <= r_rd_v;
            end
            ttd_pkg::S_RD3: begin
                r_dlast  <= r_rd_d;
                r_ds_neg <= w_ds[ttd_pkg::DIST_W];
                r_ds_mag <= w_ds[ttd_pkg::DIST_W] ? ttd_pkg::DIST_W'(-w_ds)
                                                  : w_ds[ttd_pkg::DIST_W-1:0];
                r_a    <= '0;
                r_dnum <= {7'b0, w_dv_mag, 16'b0};
                r_dden <= w_dtk_mag;
                r_drem <= '0;
                r_dcnt <= ttd_pkg::DIV_CNT_W'(DIV_STEPS);
                r_dneg <= w_dv[ttd_pkg::SPEED_W] ^ w_dtk[ttd_pkg::TIME_W];
            end
            ttd_pkg::S_DIV_A, ttd_pkg::S_DIV_T: begin
                r_drem <= w_dge ? ttd_pkg::DIV_DEN_W'(w_rem_sh - {1'b0, r_dden})
                                : w_rem_sh[ttd_pkg::DIV_DEN_W-1:0];
                r_dnum <= {r_dnum[ttd_pkg::DIV_NUM_W-2:0], w_dge};
                r_dcnt <= r_dcnt - ttd_pkg::DIV_CNT_W'(1);
            end
            ttd_pkg::S_ACLAMP: r_a <= w_a_clamp;
            ttd_pkg::S_MODE: begin
                // Linear motion: dt = ds / v0
                r_dnum <= {r_ds_mag, 16'b0};
                r_dden <= ttd_pkg::DIV_DEN_W'(r_v0);
                r_drem <= '0;
                r_dcnt <= ttd_pkg::DIV_CNT_W'(DIV_STEPS);
                r_dneg <= r_ds_neg;
                if (w_linear && r_v0 == '0) begin
                    r_zero   <= 1'b1;
                    r_status <= ttd_pkg::ST_ZERO_SPEED;
                end
            end
            ttd_pkg::S_MUL_VV: r_pad <= r_prod;
            ttd_pkg::S_ARG: begin
                if (w_arg[ttd_pkg::ARG_W-1]) begin
                    r_sx     <= '0;
                    r_status <= ttd_pkg::ST_CLAMPED;
                end else begin
                    r_sx <= ttd_pkg::SQ_W'(w_arg);
                end
                r_sres <= '0;
                r_sbit <= SQ_BIT0;
            end
            ttd_pkg::S_SQRT: begin
                if (w_sq_ge) begin
                    r_sx   <= r_sx - w_sq_try;
                    r_sres <= (r_sres >> 1) + r_sbit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            ttd_pkg::S_ROOT: begin
                // Accelerated motion: dt = (root - v0) / a
                r_dnum <= {w_diff_mag, 16'b0};
                r_dden <= ttd_pkg::DIV_DEN_W'(w_abs_a);
                r_drem <= '0;
                r_dcnt <= ttd_pkg::DIV_CNT_W'(DIV_STEPS);
                r_dneg <= w_diff[31] ^ w_a_neg;
            end
            ttd_pkg::S_DT: begin
                r_dt_mag <= w_dt_clamp;
                r_dt_neg <= r_dneg;
            end
            ttd_pkg::S_FIN: begin
                if (r_zero) begin
                    r_res_time  <= '1;
                    r_res_speed <= r_v0;
                end else begin
                    r_res_time  <= w_tm;
                    r_res_speed <= w_spd;
                end
            end
            default: begin
            end
        endcase
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (r_state == ttd_pkg::S_DONE && w_out_free) begin
            r_o_status  <= r_status;
            r_o_time    <= r_res_time;
            r_o_speed   <= r_res_speed;
            r_o_accel   <= r_a;
            r_o_segment <= ttd_pkg::INDEX_W'(r_seg);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.out_time    = r_o_time;
    assign o_rsp.out_speed   = r_o_speed;
    assign o_rsp.out_accel   = r_o_accel;
    assign o_rsp.out_segment = r_o_segment;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ttd_pkg::S_DONE)
        else $error("result shown without a finished request");

    a_store_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_status == ttd_pkg::ST_STORED) |->
            (r_o_time == '0 && r_o_speed == '0 && r_o_accel == '0 && r_o_segment == '0))
        else $error("store result carries nonzero fields");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttd_pkg::S_RD0) |-> (r_seg <= w_n - CW'(2)))
        else $error("segment index past last segment");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttd_pkg::S_DIV_T || r_state == ttd_pkg::S_DIV_A) |-> (r_dden != '0))
        else $error("divide by zero");

endmodule
